### rtl/sfa_pkg.sv
// types and constants shared by the stack frame allocator files
package sfa_pkg;

  localparam int ADDR_W = 12;
  localparam int CNT_W = 13;
  localparam int CAP_MAX = (1 << CNT_W) - 1;
  localparam int CAP_RESET = 4096;

  typedef enum logic [1:0] {
    ACT_ALLOC     = 2'd0,
    ACT_FREE_TOP  = 2'd1,
    ACT_GET_FRAME = 2'd2,
    ACT_FREE_TO   = 2'd3
  } action_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_FREED = 2'd2
  } status_e_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    action_e_t           action;
    logic [ADDR_W-1:0]   block_size;
    logic [ADDR_W-1:0]   frame_addr;
  } req_t;

  typedef struct packed {
    status_e_t           status;
    logic [ADDR_W-1:0]   address;
    logic [CNT_W-1:0]    used_total;
  } rsp_t;

endpackage

### rtl/sfa_link_ram.sv
// single-port-write, registered-read memory holding the frame links
module sfa_link_ram #(
  parameter int DEPTH = 4096,
  parameter int AW = 12,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/stack_frame_allocator.sv
// stack frame allocator top level: command decode, state update and link memory
//
// Linear stack allocator over a byte arena. A command is taken when start is
// high and busy is low; busy is then high for one cycle and the result is shown
// on result for exactly one cycle with done high. The command is held in cmd_q
// for the execute state, and result and done are registered at its end. The
// receiver cannot stall, so it must capture result whenever done
// is high. A new command can be taken in the same cycle that done is high, but
// not while the previous one is in execute; the execute state waits for the
// registered read of the link memory, whose output the pop commands need
// before the next command may see the restored frame base. The link memory is
// not cleared after reset: only entry zero has a defined reset value, and a flag
// stands in for it until it is first written, so commands are taken as soon as
// reset is released. The capacity register may be written through the cfg
// channel while no command is in flight; cfg_ready is low while busy.
module stack_frame_allocator #(
  parameter int ARENA_BYTES = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  sfa_pkg::req_t             cmd,
  output logic                      done,
  output sfa_pkg::rsp_t             result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sfa_pkg::CNT_W-1:0] cfg_data
);

  // link index width and a compare width that holds the arena size and any address
  localparam int AW = $clog2(ARENA_BYTES);
  localparam int XW = (AW + 1 > sfa_pkg::CNT_W) ? AW + 1 : sfa_pkg::CNT_W;
  localparam int CAP_LIM = (ARENA_BYTES < sfa_pkg::CAP_MAX) ? ARENA_BYTES : sfa_pkg::CAP_MAX;
  localparam int RST_CAP = (ARENA_BYTES < sfa_pkg::CAP_RESET) ? ARENA_BYTES
                                                               : sfa_pkg::CAP_RESET;
  localparam int CW = sfa_pkg::CNT_W;

  // control state
  sfa_pkg::state_t state, state_next;

  // allocator registers
  logic [CW-1:0] top, top_next;       // also the used byte count
  logic [CW-1:0] free, free_next;
  logic [AW-1:0] base, base_next;
  logic          w0;                   // link entry zero has been written

  // command held for the execute cycle
  sfa_pkg::req_t cmd_q;
  logic          rd_zero;              // link read falls outside the arena or hits unwritten entry zero

  sfa_pkg::rsp_t result_next;

  // link memory access
  logic          accept;
  logic [XW-1:0] rd_full;
  logic [XW-1:0] wr_full;
  logic          link_we;
  logic [AW-1:0] rdata;
  logic [AW-1:0] link_val;

  // datapath temporaries
  logic [CW-1:0] need;
  logic [CW-1:0] dest;
  logic [CW-1:0] cap_eff;
  logic [CW-1:0] cfg_free;

  assign accept = start && !busy;

  // free top pops to the base, free to frame pops to the given address
  assign rd_full = (cmd.action == sfa_pkg::ACT_FREE_TOP) ? XW'(base) : XW'(cmd.frame_addr);
  assign wr_full = XW'(top);

  sfa_link_ram #(
    .DEPTH (ARENA_BYTES),
    .AW    (AW),
    .DW    (AW)
  ) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (wr_full[AW-1:0]),
    .wdata (base),
    .re    (accept),
    .raddr (rd_full[AW-1:0]),
    .rdata (rdata)
  );

  assign link_val = rd_zero ? '0 : rdata;

  // capacity write, limited to the arena, reloads the free count, clipped at zero
  assign cap_eff = (cfg_data > CW'(CAP_LIM)) ? CW'(CAP_LIM) : cfg_data;
  assign cfg_free = (cap_eff > top) ? cap_eff - top : '0;

  // next state and handshake outputs
  always_comb begin
    state_next = state;
    busy = 1'b0;
    cfg_ready = 1'b0;
    case (state)
      sfa_pkg::S_IDLE: begin
        cfg_ready = 1'b1;
        if (start) begin
          state_next = sfa_pkg::S_EXEC;
        end
      end
      sfa_pkg::S_EXEC: begin
        busy = 1'b1;
        state_next = sfa_pkg::S_IDLE;
      end
      default: begin
        state_next = sfa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // execute: read-modify-write of the allocator state
  always_comb begin
    top_next = top;
    free_next = free;
    base_next = base;
    link_we = 1'b0;
    result_next.status = sfa_pkg::ST_OK;
    result_next.address = '0;
    need = CW'(cmd_q.block_size) + CW'(HEADER_BYTES);
    dest = (cmd_q.action == sfa_pkg::ACT_FREE_TOP) ? CW'(base) : CW'(cmd_q.frame_addr);
    case (cmd_q.action)
      sfa_pkg::ACT_ALLOC: begin
        if (need > free) begin
          result_next.status = sfa_pkg::ST_FULL;
        end else begin
          link_we = (state == sfa_pkg::S_EXEC) && (wr_full < XW'(ARENA_BYTES));
          base_next = AW'(top);
          top_next = top + need;
          free_next = free - need;
          result_next.address = sfa_pkg::ADDR_W'(top + CW'(HEADER_BYTES));
        end
      end
      sfa_pkg::ACT_FREE_TOP: begin
        top_next = dest;
        free_next = free + (top - dest);
        base_next = link_val;
      end
      sfa_pkg::ACT_GET_FRAME: begin
        result_next.address = sfa_pkg::ADDR_W'(base);
      end
      sfa_pkg::ACT_FREE_TO: begin
        if (dest > top) begin
          result_next.status = sfa_pkg::ST_FREED;
        end else begin
          top_next = dest;
          free_next = free + (top - dest);
          base_next = link_val;
        end
      end
      default: begin
      end
    endcase
    result_next.used_total = top_next;
  end

  // control and allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
      free <= CW'(RST_CAP);
      base <= '0;
      w0 <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (state == sfa_pkg::S_EXEC);
      if (state == sfa_pkg::S_EXEC) begin
        top <= top_next;
        free <= free_next;
        base <= base_next;
        if (link_we && (wr_full == '0)) begin
          w0 <= 1'b1;
        end
      end else if (cfg_valid && cfg_ready) begin
        free <= cfg_free;
      end
    end
  end

  // payload registers for the command and its result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      rd_zero <= (rd_full >= XW'(ARENA_BYTES)) || ((rd_full == '0) && !w0);
    end
    if (state == sfa_pkg::S_EXEC) begin
      result <= result_next;
    end
  end

  // result transaction follows every execute cycle
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == sfa_pkg::S_EXEC) |=> done)
    else $error("result strobe missing after execute");

  // no result strobe while a command is still in execute
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe during execute");

  // used plus free bytes never exceed the effective capacity bound
  a_bytes_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, top} + {1'b0, free}) <= (CW + 1)'(CAP_LIM))
    else $error("used plus free bytes exceed the arena");

  // a rejected allocate leaves the top and the base unchanged
  a_full_keeps_top: assert property (@(posedge clk) disable iff (rst)
    (state == sfa_pkg::S_EXEC && cmd_q.action == sfa_pkg::ACT_ALLOC && need > free)
    |=> (top == $past(top)) && (base == $past(base)))
    else $error("failed allocate changed the stack");

  // a command cannot be taken while the link read of the previous one is pending
  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (rst)
    (state == sfa_pkg::S_EXEC) |-> !accept)
    else $error("command taken during execute");

endmodule

### tb/stack_frame_allocator_tb.sv
// self-checking testbench for the stack frame allocator
`timescale 1ns / 100ps

package sfa_tb_pkg;

  localparam int ARENA = 4096;
  localparam int HDR = 8;
  localparam int MAX_SHOWN = 20;
  localparam int CNT_W = sfa_pkg::CNT_W;
  localparam int ADDR_W = sfa_pkg::ADDR_W;

  // tracks the allocator state, predicts each result and checks it
  class alloc_tracker;
    logic [CNT_W-1:0]  capacity;
    logic [CNT_W-1:0]  top;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free_cnt;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] links [ARENA];
    bit                written [ARENA];
    sfa_pkg::rsp_t     pending_results [$];
    int                errors;
    int                n_cmds;
    int                n_cfg;
    int                n_ok;
    int                n_full;
    int                n_freed;
    logic [CNT_W-1:0]  peak;

    function new();
      capacity = CNT_W'(sfa_pkg::CAP_RESET);
      top      = '0;
      used     = '0;
      base     = '0;
      free_cnt = CNT_W'(ARENA);
      peak     = '0;
      foreach (links[i]) begin
        links[i]   = '0;
        written[i] = 1'b0;
      end
      // entry zero has a defined value from reset
      written[0] = 1'b1;
      errors = 0;
      n_cmds = 0;
      n_cfg = 0;
      n_ok = 0;
      n_full = 0;
      n_freed = 0;
    endfunction

    task report(string what, int got_v, int want_v);
      errors++;
      if (errors <= MAX_SHOWN)
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got_v, want_v);
    endtask

    function void set_capacity(logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] eff;
      capacity = v;
      eff = (v < ARENA) ? v : CNT_W'(ARENA);
      free_cnt = (eff > used) ? eff - used : '0;
      n_cfg++;
    endfunction

    function void pop_to(logic [CNT_W-1:0] dest);
      logic [CNT_W-1:0] n;
      n = top - dest;
      top = dest;
      base = (dest < ARENA) ? links[dest[ADDR_W-1:0]] : '0;
      used -= n;
      free_cnt += n;
    endfunction

    // one accepted command transaction: update state, queue the expected result
    function void note_cmd(sfa_pkg::req_t c);
      sfa_pkg::rsp_t    r;
      logic [CNT_W-1:0] need;
      r = '0;
      r.status = sfa_pkg::ST_OK;
      case (c.action)
        sfa_pkg::ACT_ALLOC: begin
          need = CNT_W'(c.block_size) + CNT_W'(HDR);
          if (need > free_cnt) begin
            r.status = sfa_pkg::ST_FULL;
          end else begin
            if (top < ARENA) begin
              links[top[ADDR_W-1:0]] = base;
              written[top[ADDR_W-1:0]] = 1'b1;
            end
            base = top[ADDR_W-1:0];
            top += need;
            used += need;
            free_cnt -= need;
            r.address = base + ADDR_W'(HDR);
          end
        end
        sfa_pkg::ACT_FREE_TOP: pop_to(CNT_W'(base));
        sfa_pkg::ACT_GET_FRAME: r.address = base;
        default: begin
          if (CNT_W'(c.frame_addr) > top) r.status = sfa_pkg::ST_FREED;
          else pop_to(CNT_W'(c.frame_addr));
        end
      endcase
      r.used_total = used;
      if (used > peak) peak = used;
      n_cmds++;
      pending_results.push_back(r);
    endfunction

    task check_result(sfa_pkg::rsp_t got);
      sfa_pkg::rsp_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing expected, used_total", int'(got.used_total), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report("status", int'(got.status), int'(want.status));
        if (got.address !== want.address)
          report("address", int'(got.address), int'(want.address));
        if (got.used_total !== want.used_total)
          report("used_total", int'(got.used_total), int'(want.used_total));
        case (want.status)
          sfa_pkg::ST_FULL:  n_full++;
          sfa_pkg::ST_FREED: n_freed++;
          default:           n_ok++;
        endcase
      end
    endtask
  endclass
endpackage

module stack_frame_allocator_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ANY = -1;
  localparam int RANDOM_PHASE_ITEMS = 120;
  localparam int ARENA = sfa_tb_pkg::ARENA;
  localparam int HDR = sfa_tb_pkg::HDR;
  localparam int CNT_W = sfa_pkg::CNT_W;
  localparam int ADDR_W = sfa_pkg::ADDR_W;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  sfa_pkg::req_t     cmd;
  logic              done;
  sfa_pkg::rsp_t     result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data;

  sfa_tb_pkg::alloc_tracker sb;
  bit                burst;
  int                idle_cycles = 0;

  stack_frame_allocator #(
    .ARENA_BYTES (ARENA),
    .HEADER_BYTES(HDR)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // results cannot be held off, so every strobe is checked at the edge that ends it
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // watchdog: any accepted transaction restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("stack_frame_allocator_tb: done, errors");
      $finish;
    end
  end

  function automatic int draw_gap();
    return burst ? 0 : int'($urandom_range(0, 4));
  endfunction

  // drive one command transaction; returns at the edge that accepts it
  // start is only touched once per falling edge so back-to-back commands keep it high
  task automatic send_cmd(sfa_pkg::req_t c, int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    sb.note_cmd(c);
  endtask

  // build a command, unused or ANY fields are filled with noise
  task automatic issue(sfa_pkg::action_e_t a, int size, int frame);
    sfa_pkg::req_t c;
    c.action     = a;
    c.block_size = (size < 0) ? ADDR_W'($urandom) : ADDR_W'(size);
    c.frame_addr = (frame < 0) ? ADDR_W'($urandom) : ADDR_W'(frame);
    send_cmd(c, draw_gap());
  endtask

  // sender holds off until every expected result is back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // capacity write, only issued with the block idle
  task automatic write_capacity(int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_W'(v);
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(CNT_W'(v));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random mix of well-formed stack traffic with some noise
  task automatic random_phase(int n);
    sfa_pkg::req_t c;
    int   sel;
    int   lim;
    int   r;
    int   top_now;
    for (int i = 0; i < n; i++) begin
      c.frame_addr = ADDR_W'($urandom);
      sel = $urandom_range(0, 9);
      if (sel < 7) c.block_size = ADDR_W'($urandom_range(0, 31));
      else if (sel < 9) c.block_size = ADDR_W'($urandom_range(0, 255));
      else c.block_size = ADDR_W'($urandom_range(0, 4095));
      sel = $urandom_range(0, 99);
      if (sel < 55) c.action = sfa_pkg::ACT_ALLOC;
      else if (sel < 70) c.action = sfa_pkg::ACT_FREE_TOP;
      else if (sel < 80) c.action = sfa_pkg::ACT_GET_FRAME;
      else c.action = sfa_pkg::ACT_FREE_TO;
      if (c.action == sfa_pkg::ACT_FREE_TO) begin
        top_now = int'(sb.top);
        if ($urandom_range(0, 3) == 0 && top_now < ARENA - 1) begin
          // frame above the top
          c.frame_addr = ADDR_W'($urandom_range(top_now + 1, ARENA - 1));
        end else begin
          // a frame at or below the top whose link was written
          lim = (top_now > ARENA - 1) ? ARENA - 1 : top_now;
          r = $urandom_range(0, lim);
          while (!sb.written[r]) r--;
          c.frame_addr = ADDR_W'(r);
        end
      end
      send_cmd(c, draw_gap());
    end
  endtask

  initial begin
    int caps [9];
    caps = '{4096, 64, 16, 1500, 4096, 300, 2048, 4096, 700};
    sb = new();
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    burst     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty stack cases, fill and pop at the reset capacity
    issue(sfa_pkg::ACT_GET_FRAME, ANY, ANY);
    issue(sfa_pkg::ACT_FREE_TOP, ANY, ANY);         // zero-byte pop on an empty stack
    issue(sfa_pkg::ACT_FREE_TO, ANY, 0);            // free to frame zero while empty
    issue(sfa_pkg::ACT_FREE_TO, ANY, 4095);         // frame above the top
    issue(sfa_pkg::ACT_ALLOC, 0, ANY);
    issue(sfa_pkg::ACT_ALLOC, 4095, ANY);           // never fits
    issue(sfa_pkg::ACT_ALLOC, 100, ANY);
    issue(sfa_pkg::ACT_GET_FRAME, ANY, ANY);
    issue(sfa_pkg::ACT_ALLOC, 20, ANY);
    issue(sfa_pkg::ACT_FREE_TO, ANY, 8);            // back to an inner frame
    issue(sfa_pkg::ACT_FREE_TOP, ANY, ANY);
    issue(sfa_pkg::ACT_ALLOC, ARENA - HDR, ANY);    // fills the arena exactly
    issue(sfa_pkg::ACT_ALLOC, 0, ANY);              // full
    issue(sfa_pkg::ACT_GET_FRAME, ANY, ANY);
    issue(sfa_pkg::ACT_FREE_TOP, ANY, ANY);
    issue(sfa_pkg::ACT_ALLOC, 4000, ANY);
    issue(sfa_pkg::ACT_ALLOC, 80, ANY);             // top reaches the arena end
    drain();
    // capacity below the bytes in use
    write_capacity(16);
    issue(sfa_pkg::ACT_ALLOC, 0, ANY);
    issue(sfa_pkg::ACT_FREE_TOP, ANY, ANY);
    issue(sfa_pkg::ACT_FREE_TO, ANY, 0);
    drain();
    write_capacity(16);
    issue(sfa_pkg::ACT_ALLOC, 8, ANY);              // exactly the smallest capacity
    issue(sfa_pkg::ACT_ALLOC, 0, ANY);
    issue(sfa_pkg::ACT_FREE_TO, ANY, 0);
    drain();

    // random phases, stack contents carry over across capacity changes
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      burst = (p % 2) == 1;
      random_phase(RANDOM_PHASE_ITEMS);
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report("results never produced", 0, sb.pending_results.size());

    $display("covered %0d command transactions and %0d capacity writes over 16..4096 bytes",
             sb.n_cmds, sb.n_cfg);
    $display("results: %0d ok, %0d arena full, %0d above-top frees, peak use %0d bytes",
             sb.n_ok, sb.n_full, sb.n_freed, sb.peak);
    if (sb.errors == 0) begin
      $display("stack_frame_allocator_tb: done, clean");
    end else begin
      $display("stack_frame_allocator_tb: done, errors");
    end
    $finish;
  end
endmodule
